/* rtl/core/rcdt_pkg.sv */
`default_nettype none
package rcdt_pkg;

    localparam int ENTRIES    = 64;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;
    localparam int SLOT_BITS  = $clog2(ENTRIES);
    localparam int LEVEL_BITS = SLOT_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = LEVEL_BITS'(ENTRIES);

    typedef enum logic [0:0] {
        OP_ADD     = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_ADDED  = 3'd0,
        ST_SHARED = 3'd1,
        ST_FULL   = 3'd2,
        ST_FREED  = 3'd3,
        ST_HELD   = 3'd4,
        ST_DEAD   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT_WR,
        S_ALLOC,
        S_REL,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_opcode                opcode;
        logic [VALUE_BITS-1:0]  value;
        logic [SLOT_BITS-1:0]   slot;
        logic                   return_value;
    } t_req;

    typedef struct packed {
        logic [SLOT_BITS-1:0]   slot_out;
        logic [VALUE_BITS-1:0]  value_out;
        t_status                status;
    } t_rsp;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  count;
        logic [VALUE_BITS-1:0]  value;
    } t_entry;

    typedef struct packed {
        logic                   rd_en;
        logic [SLOT_BITS-1:0]   rd_addr;
        logic                   wr_en;
        logic [SLOT_BITS-1:0]   wr_addr;
        t_entry                 wr_data;
    } t_ent_cmd;

    typedef struct packed {
        logic                   rd_en;
        logic [SLOT_BITS-1:0]   rd_addr;
        logic                   wr_en;
        logic [SLOT_BITS-1:0]   wr_addr;
        logic [SLOT_BITS-1:0]   wr_data;
    } t_stk_cmd;

endpackage
`default_nettype wire

/* rtl/core/rcdt_entry_store.sv */
`default_nettype none
module rcdt_entry_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rcdt_pkg::t_ent_cmd i_cmd,
    output rcdt_pkg::t_entry        o_rd_data
);

    rcdt_pkg::t_entry                mem [rcdt_pkg::ENTRIES];
    logic [rcdt_pkg::ENTRIES-1:0]    r_written;
    rcdt_pkg::t_entry                r_rd_data;
    logic                            r_rd_written;

    // entry data, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_cmd.rd_addr];
        end
    end

    // written flags stand for the all-zero count after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_written[i_cmd.wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_written <= r_written[i_cmd.rd_addr];
            end
        end
    end

    always_comb begin
        o_rd_data       = r_rd_data;
        o_rd_data.count = r_rd_written ? r_rd_data.count : '0;
    end

endmodule
`default_nettype wire

/* rtl/core/rcdt_stack_ram.sv */
`default_nettype none
module rcdt_stack_ram (
    input  wire logic                          i_clk,
    input  wire rcdt_pkg::t_stk_cmd            i_cmd,
    output logic [rcdt_pkg::SLOT_BITS-1:0]     o_rd_data
);

    logic [rcdt_pkg::SLOT_BITS-1:0] mem [rcdt_pkg::ENTRIES];
    logic [rcdt_pkg::SLOT_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_cmd.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* rtl/core/refcounted_dedup_table_unit.sv */
// add: one entry compared per cycle below the high-water mark through the entry memory read
// port; release: reads its entry first; one request in flight, the next one taken only after
// the last result has entered the output register, which waits while the output is stalled
// reset: synchronous active low, clears control, high-water, free depth and written flags;
// memories are not swept, so requests are taken right after reset
`default_nettype none
module refcounted_dedup_table_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire rcdt_pkg::t_req   i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output rcdt_pkg::t_rsp        o_out_data
);

    localparam int SB = rcdt_pkg::SLOT_BITS;
    localparam int LB = rcdt_pkg::LEVEL_BITS;

    // control state
    rcdt_pkg::t_state   r_state, n_state;
    logic [LB-1:0]      r_hw, n_hw;          // high-water mark
    logic [LB-1:0]      r_depth, n_depth;    // free stack depth
    logic [LB-1:0]      r_idx, n_idx;        // scan read pointer
    logic               r_chk_v, n_chk_v;    // a scan read is returning this cycle
    logic               r_out_valid, n_out_valid;

    // payload registers
    rcdt_pkg::t_req     r_req, n_req;
    logic [SB-1:0]      r_chk_idx, n_chk_idx;
    logic [SB-1:0]      r_pick, n_pick;
    logic               r_from_stack, n_from_stack;
    logic [rcdt_pkg::COUNT_BITS-1:0] r_hit_cnt, n_hit_cnt;
    rcdt_pkg::t_rsp     r_res, n_res;
    rcdt_pkg::t_rsp     r_out, n_out;

    // memory ports
    rcdt_pkg::t_ent_cmd ent_cmd;
    rcdt_pkg::t_entry   ent_rd;
    rcdt_pkg::t_stk_cmd stk_cmd;
    logic [SB-1:0]      stk_rd;

    // shared decode
    logic               in_accept;
    logic               out_free;
    logic               scan_issue;
    logic               scan_hit;
    logic               scan_done;
    logic               rel_dead;
    logic [rcdt_pkg::COUNT_BITS-1:0] rel_cnt;
    logic [SB-1:0]      alloc_slot;

    rcdt_entry_store u_entry_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (ent_cmd),
        .o_rd_data (ent_rd)
    );

    rcdt_stack_ram u_stack_ram (
        .i_clk     (i_clk),
        .i_cmd     (stk_cmd),
        .o_rd_data (stk_rd)
    );

    assign o_in_stall  = (r_state != rcdt_pkg::S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    // scan pipeline: issue one read per cycle below high-water, compare the returning one
    assign scan_issue = (r_state == rcdt_pkg::S_SCAN) && (r_idx < r_hw);
    assign scan_hit   = r_chk_v && (ent_rd.count != '0) && (ent_rd.value == r_req.value);
    assign scan_done  = !scan_issue && !r_chk_v;

    // release checks on the entry read in the previous cycle
    assign rel_dead   = ({1'b0, r_req.slot} >= r_hw) || (ent_rd.count == '0);
    assign rel_cnt    = ent_rd.count - rcdt_pkg::COUNT_BITS'(1);

    // a freshly taken slot comes from the stack read or from the high-water mark
    assign alloc_slot = r_from_stack ? stk_rd : r_pick;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rcdt_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in_data.opcode == rcdt_pkg::OP_RELEASE) ?
                              rcdt_pkg::S_REL : rcdt_pkg::S_SCAN;
                end
            end
            rcdt_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_state = rcdt_pkg::S_HIT_WR;
                end else if (scan_done) begin
                    if (r_depth != '0 || r_hw < rcdt_pkg::LEVEL_FULL) begin
                        n_state = rcdt_pkg::S_ALLOC;
                    end else begin
                        n_state = rcdt_pkg::S_EMIT;
                    end
                end
            end
            rcdt_pkg::S_HIT_WR: n_state = rcdt_pkg::S_EMIT;
            rcdt_pkg::S_ALLOC:  n_state = rcdt_pkg::S_EMIT;
            rcdt_pkg::S_REL:    n_state = rcdt_pkg::S_EMIT;
            rcdt_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = rcdt_pkg::S_IDLE;
                end
            end
            default: n_state = rcdt_pkg::S_IDLE;
        endcase
    end

    // datapath and memory commands
    always_comb begin
        n_hw         = r_hw;
        n_depth      = r_depth;
        n_idx        = r_idx;
        n_chk_v      = 1'b0;
        n_req        = r_req;
        n_chk_idx    = r_chk_idx;
        n_pick       = r_pick;
        n_from_stack = r_from_stack;
        n_hit_cnt    = r_hit_cnt;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;

        ent_cmd         = '0;
        ent_cmd.rd_addr = r_idx[SB-1:0];
        stk_cmd         = '0;

        case (r_state)
            rcdt_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_req = i_in_data;
                    n_idx = '0;
                    // release reads its entry right away
                    if (i_in_data.opcode == rcdt_pkg::OP_RELEASE) begin
                        ent_cmd.rd_en   = 1'b1;
                        ent_cmd.rd_addr = i_in_data.slot;
                    end
                end
            end
            rcdt_pkg::S_SCAN: begin
                if (scan_issue) begin
                    ent_cmd.rd_en = 1'b1;
                    n_chk_v       = 1'b1;
                    n_chk_idx     = r_idx[SB-1:0];
                    n_idx         = r_idx + LB'(1);
                end
                if (scan_hit) begin
                    n_pick    = r_chk_idx;
                    n_hit_cnt = ent_rd.count;
                end else if (scan_done) begin
                    if (r_depth != '0) begin
                        // pop: read the top of the free stack
                        stk_cmd.rd_en   = 1'b1;
                        stk_cmd.rd_addr = SB'(r_depth - LB'(1));
                        n_depth         = r_depth - LB'(1);
                        n_from_stack    = 1'b1;
                    end else if (r_hw < rcdt_pkg::LEVEL_FULL) begin
                        n_pick       = r_hw[SB-1:0];
                        n_hw         = r_hw + LB'(1);
                        n_from_stack = 1'b0;
                    end else begin
                        n_res.slot_out  = '0;
                        n_res.value_out = '0;
                        n_res.status    = rcdt_pkg::ST_FULL;
                    end
                end
            end
            rcdt_pkg::S_HIT_WR: begin
                // count saturates at its maximum
                ent_cmd.wr_en         = 1'b1;
                ent_cmd.wr_addr       = r_pick;
                ent_cmd.wr_data.value = r_req.value;
                ent_cmd.wr_data.count = (r_hit_cnt == rcdt_pkg::COUNT_MAX) ?
                                        r_hit_cnt : r_hit_cnt + rcdt_pkg::COUNT_BITS'(1);
                n_res.slot_out        = r_pick;
                n_res.value_out       = '0;
                n_res.status          = rcdt_pkg::ST_SHARED;
            end
            rcdt_pkg::S_ALLOC: begin
                ent_cmd.wr_en         = 1'b1;
                ent_cmd.wr_addr       = alloc_slot;
                ent_cmd.wr_data.value = r_req.value;
                ent_cmd.wr_data.count = rcdt_pkg::COUNT_BITS'(1);
                n_res.slot_out        = alloc_slot;
                n_res.value_out       = '0;
                n_res.status          = rcdt_pkg::ST_ADDED;
            end
            rcdt_pkg::S_REL: begin
                n_res.slot_out  = r_req.slot;
                n_res.value_out = '0;
                if (rel_dead) begin
                    n_res.status = rcdt_pkg::ST_DEAD;
                end else begin
                    if (r_req.return_value) begin
                        n_res.value_out = ent_rd.value;
                    end
                    ent_cmd.wr_en         = 1'b1;
                    ent_cmd.wr_addr       = r_req.slot;
                    ent_cmd.wr_data.value = ent_rd.value;
                    ent_cmd.wr_data.count = rel_cnt;
                    if (rel_cnt != '0) begin
                        n_res.status = rcdt_pkg::ST_HELD;
                    end else begin
                        n_res.status = rcdt_pkg::ST_FREED;
                        // top slot shrinks the mark, any other goes on the free stack
                        if ({1'b0, r_req.slot} + LB'(1) == r_hw) begin
                            n_hw = r_hw - LB'(1);
                        end else if (r_depth < rcdt_pkg::LEVEL_FULL) begin
                            stk_cmd.wr_en   = 1'b1;
                            stk_cmd.wr_addr = r_depth[SB-1:0];
                            stk_cmd.wr_data = r_req.slot;
                            n_depth         = r_depth + LB'(1);
                        end
                    end
                end
            end
            rcdt_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcdt_pkg::S_IDLE;
            r_hw        <= '0;
            r_depth     <= '0;
            r_idx       <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hw        <= n_hw;
            r_depth     <= n_depth;
            r_idx       <= n_idx;
            r_chk_v     <= n_chk_v;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_chk_idx    <= n_chk_idx;
        r_pick       <= n_pick;
        r_from_stack <= n_from_stack;
        r_hit_cnt    <= n_hit_cnt;
        r_res        <= n_res;
        r_out        <= n_out;
    end

endmodule
`default_nettype wire

/* dv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // run limit: about nine hundred requests, each at most a full scan plus heavy idling
    localparam int CYCLE_LIMIT  = 1_000_000;
    // longest add compares every slot below the high-water mark, then allocates and emits
    localparam int DRAIN_CYCLES = rcdt_pkg::ENTRIES + 16;
    localparam int POOL_SIZE    = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // request side
    logic req_valid = 1'b0;
    logic req_stall;
    rcdt_pkg::t_req req_data = '0;

    // result side
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rcdt_pkg::t_rsp rsp_data;

    // idling knobs, in percent per cycle
    int req_idle_pct = 0;
    int rsp_stall_pct = 0;

    int error_count = 0;
    int cycle_count = 0;

    // shadow copy of the interning table
    logic [rcdt_pkg::VALUE_BITS-1:0] shadow_value [rcdt_pkg::ENTRIES];
    logic [rcdt_pkg::COUNT_BITS-1:0] shadow_count [rcdt_pkg::ENTRIES];
    logic [rcdt_pkg::SLOT_BITS-1:0]  shadow_free  [rcdt_pkg::ENTRIES];
    int unsigned                     shadow_hw;
    int unsigned                     shadow_free_depth;

    // answers owed by the table, oldest first
    rcdt_pkg::t_rsp table_answers [$];

    // small set of values that recur, so adds often hit live entries
    logic [rcdt_pkg::VALUE_BITS-1:0] value_pool [POOL_SIZE];

    always #5 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    refcounted_dedup_table_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .o_out_data  (rsp_data)
    );

    // apply one request to the shadow table and return the answer it owes
    function automatic rcdt_pkg::t_rsp intern_predict(rcdt_pkg::t_req r);
        rcdt_pkg::t_rsp ans;
        ans = '0;
        if (r.opcode == rcdt_pkg::OP_ADD) begin
            // look for a live entry holding the same value below the high-water mark
            for (int i = 0; i < shadow_hw; i++) begin
                if (shadow_count[i] != '0 && shadow_value[i] == r.value) begin
                    // counts stick at their maximum
                    if (shadow_count[i] != rcdt_pkg::COUNT_MAX)
                        shadow_count[i] = shadow_count[i] + 1'b1;
                    ans.slot_out = rcdt_pkg::SLOT_BITS'(i);
                    ans.status = rcdt_pkg::ST_SHARED;
                    return ans;
                end
            end
            // no match: freed slots first (last freed, first reused), then fresh ones
            if (shadow_free_depth > 0) begin
                shadow_free_depth--;
                ans.slot_out = shadow_free[shadow_free_depth];
            end else if (shadow_hw < rcdt_pkg::ENTRIES) begin
                ans.slot_out = rcdt_pkg::SLOT_BITS'(shadow_hw);
                shadow_hw++;
            end else begin
                // table full, nothing changes
                ans.status = rcdt_pkg::ST_FULL;
                return ans;
            end
            shadow_value[ans.slot_out] = r.value;
            shadow_count[ans.slot_out] = rcdt_pkg::COUNT_BITS'(1);
            ans.status = rcdt_pkg::ST_ADDED;
        end else begin
            ans.slot_out = r.slot;
            // dead slot: at or above the high-water mark or count already zero
            if (r.slot >= shadow_hw || shadow_count[r.slot] == '0) begin
                ans.status = rcdt_pkg::ST_DEAD;
                return ans;
            end
            if (r.return_value)
                ans.value_out = shadow_value[r.slot];
            shadow_count[r.slot] = shadow_count[r.slot] - 1'b1;
            if (shadow_count[r.slot] != '0) begin
                ans.status = rcdt_pkg::ST_HELD;
                return ans;
            end
            // last reference gone: top slot shrinks the mark, others go on the free stack
            if (r.slot + 1 == shadow_hw) begin
                shadow_hw--;
            end else if (shadow_free_depth < rcdt_pkg::ENTRIES) begin
                shadow_free[shadow_free_depth] = r.slot;
                shadow_free_depth++;
            end
            ans.status = rcdt_pkg::ST_FREED;
        end
        return ans;
    endfunction

    // add request, release fields filled with noise
    function automatic rcdt_pkg::t_req add_req(logic [rcdt_pkg::VALUE_BITS-1:0] v);
        rcdt_pkg::t_req r;
        r.opcode = rcdt_pkg::OP_ADD;
        r.value = v;
        r.slot = rcdt_pkg::SLOT_BITS'($urandom);
        r.return_value = 1'($urandom);
        return r;
    endfunction

    // release request, add field filled with noise
    function automatic rcdt_pkg::t_req release_req(logic [rcdt_pkg::SLOT_BITS-1:0] s,
                                                   logic want);
        rcdt_pkg::t_req r;
        r.opcode = rcdt_pkg::OP_RELEASE;
        r.value = $urandom;
        r.slot = s;
        r.return_value = want;
        return r;
    endfunction

    // drive one request, wait for the handshake, log the owed answer at acceptance
    task automatic send_req(input rcdt_pkg::t_req r, output rcdt_pkg::t_rsp ans);
        logic took;
        // random gap before the request; valid only drops when a gap is taken
        while ($urandom_range(99) < req_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        // stall is looked at mid-cycle, where nothing moves
        do begin
            @(negedge clk);
            took = !req_stall;
            @(posedge clk);
        end while (!took);
        ans = intern_predict(r);
        table_answers.push_back(ans);
    endtask

    // result stall pattern, redrawn every cycle
    always @(posedge clk)
        rsp_stall <= (rsp_stall_pct > 0) && ($urandom_range(99) < rsp_stall_pct);

    // result checker: a result shown mid-cycle with stall low is taken at the next edge
    always @(negedge clk) begin
        rcdt_pkg::t_rsp want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (table_answers.size() == 0) begin
                $error("unexpected result: slot_out %0d value_out %h status %0d",
                       rsp_data.slot_out, rsp_data.value_out, rsp_data.status);
                error_count++;
            end else begin
                want = table_answers.pop_front();
                if (rsp_data.slot_out !== want.slot_out) begin
                    $error("slot_out: expected %0d, actual %0d",
                           want.slot_out, rsp_data.slot_out);
                    error_count++;
                end
                if (rsp_data.value_out !== want.value_out) begin
                    $error("value_out: expected %h, actual %h",
                           want.value_out, rsp_data.value_out);
                    error_count++;
                end
                if (rsp_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d",
                           want.status, rsp_data.status);
                    error_count++;
                end
            end
        end
    end

    // releases on an empty table are all dead, including both slot extremes
    task automatic test_dead_release();
        rcdt_pkg::t_rsp ans;
        req_idle_pct = 0;
        rsp_stall_pct = 0;
        send_req(release_req('0, 1'b1), ans);
        send_req(release_req('1, 1'b1), ans);
        send_req(release_req(rcdt_pkg::SLOT_BITS'(17), 1'b0), ans);
    endtask

    // sharing, freeing the top slot and a lower slot, free stack reuse, dead slots
    task automatic test_add_release();
        rcdt_pkg::t_rsp a0;
        rcdt_pkg::t_rsp a1;
        rcdt_pkg::t_rsp a2;
        rcdt_pkg::t_rsp ans;
        req_idle_pct = 0;
        rsp_stall_pct = 0;
        send_req(add_req('0), a0);
        send_req(add_req(32'h0000_0001), a1);
        send_req(add_req(32'h8000_0000), a2);
        // same value again shares the first entry
        send_req(add_req('0), ans);
        // still referenced, value returned
        send_req(release_req(a0.slot_out, 1'b1), ans);
        // top slot freed, high-water mark drops
        send_req(release_req(a2.slot_out, 1'b1), ans);
        // lowest slot freed onto the stack, no value asked for
        send_req(release_req(a0.slot_out, 1'b0), ans);
        // zero count below the mark is dead
        send_req(release_req(a0.slot_out, 1'b1), ans);
        // far above the mark is dead
        send_req(release_req(rcdt_pkg::SLOT_BITS'(rcdt_pkg::ENTRIES - 1), 1'b1), ans);
        // new value should come off the free stack
        send_req(add_req(32'h5A5A_A5A5), ans);
        send_req(add_req(32'h0000_0001), ans);
    endtask

    // fill every slot, hit the full case, then empty the table from the top down
    task automatic test_table_full();
        rcdt_pkg::t_rsp ans;
        req_idle_pct = 26;
        rsp_stall_pct = 26;
        while (!(shadow_hw == rcdt_pkg::ENTRIES && shadow_free_depth == 0))
            send_req(add_req($urandom), ans);
        // fresh values find no room
        repeat (2) send_req(add_req($urandom), ans);
        // a live value still shares when full
        send_req(add_req(shadow_value[rcdt_pkg::ENTRIES - 1]), ans);
        // descending order lets the mark shrink step by step
        for (int s = rcdt_pkg::ENTRIES - 1; s >= 0; s--) begin
            while (s < shadow_hw && shadow_count[s] != '0)
                send_req(release_req(rcdt_pkg::SLOT_BITS'(s), 1'($urandom)), ans);
        end
    endtask

    // mixed traffic: adds from the pool or fresh, releases mostly of live slots
    task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
        rcdt_pkg::t_rsp ans;
        int live [$];
        logic [rcdt_pkg::VALUE_BITS-1:0] v;
        req_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            live.delete();
            for (int i = 0; i < shadow_hw; i++)
                if (shadow_count[i] != '0)
                    live.push_back(i);
            if (live.size() == 0 || $urandom_range(99) < 55) begin
                if ($urandom_range(1))
                    v = value_pool[$urandom_range(POOL_SIZE - 1)];
                else
                    v = $urandom;
                send_req(add_req(v), ans);
            end else if ($urandom_range(9) < 8) begin
                send_req(release_req(
                             rcdt_pkg::SLOT_BITS'(live[$urandom_range(live.size() - 1)]),
                             1'($urandom)), ans);
            end else begin
                // any slot at all, mostly dead ones
                send_req(release_req(rcdt_pkg::SLOT_BITS'($urandom), 1'($urandom)), ans);
            end
        end
    endtask

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        // shadow table starts empty, as the block does after reset
        for (int i = 0; i < rcdt_pkg::ENTRIES; i++)
            shadow_count[i] = '0;
        shadow_hw = 0;
        shadow_free_depth = 0;

        // pool carries both value extremes, two single-bit patterns and random values
        value_pool[0] = '0;
        value_pool[1] = '1;
        value_pool[2] = 32'h0000_0001;
        value_pool[3] = 32'h8000_0000;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_dead_release();
        test_add_release();
        test_table_full();

        // idling phases: none, sender gaps, result stalls, both
        test_random(190, 0, 0);
        test_random(190, 85, 0);
        test_random(190, 0, 85);
        test_random(190, 26, 26);

        req_valid <= 1'b0;

        // wait for every owed answer, then make sure nothing extra shows up
        while (table_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
